// ----- rtl/bmhq_pkg.sv -----
// Package for the binary min-heap queue unit.
// Holds the sequencer state type and the operation codes; no dependencies.
package bmhq_pkg;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_LAST_RD,
    ST_DN_LAST,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_PICK,
    ST_DN_SWP,
    ST_DONE
  } bmhq_state_e;

endpackage

// ----- rtl/bmhq_if.sv -----
// Valid/ready channel interfaces of the binary min-heap queue unit.
// Request channel carries mode and value; response channel carries the status fields.
interface bmhq_req_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface bmhq_rsp_if #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 11
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] min_value;
  logic signed [VALUE_WIDTH-1:0] removed_value;
  logic        [COUNT_WIDTH-1:0] count;
  logic                          empty_res;
  logic                          error;

  modport source (output valid, output min_value, output removed_value, output count,
                  output empty_res, output error, input ready);
  modport sink   (input valid, input min_value, input removed_value, input count,
                  input empty_res, input error, output ready);
endinterface

// ----- rtl/bmhq_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ----- rtl/binary_min_heap_queue_unit.sv -----
// Binary min-heap priority queue of signed values, stored in one RAM and sifted by a
// small sequencer around a single signed comparator; uses bmhq_pkg, bmhq_if, bmhq_ram.
//
// Each request (insert value, or remove minimum) returns one response with the minimum,
// the removed value, the count, an empty flag and an error flag; an insert into a full
// heap or a remove from an empty heap is refused with error set. The unit handles one
// request at a time and drops ready until its response is registered. The RAM has one
// read port with registered data, so an insert rises one level per read of the parent
// and compare-and-write, and a remove takes the last value as the new root and sinks it
// one level per read of the children, pick of the smaller child and compare-and-swap;
// a refused request or the removal of the last value goes straight to the final step.
// A response waiting on the output holds the next request in the final step.
module binary_min_heap_queue_unit
  import bmhq_pkg::*;
#(
  parameter int CAPACITY    = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bmhq_req_if.sink   in_i,
  bmhq_rsp_if.source out_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = AW + 1;
  localparam int CW = $clog2(CAPACITY + 1);

  bmhq_state_e state_q, state_d;

  logic        [AW-1:0]          pos_q, pos_d;
  logic        [AW-1:0]          pick_q, pick_d;
  logic        [CW-1:0]          cnt_q, cnt_d;
  logic signed [VALUE_WIDTH-1:0] cur_q, cur_d;
  logic signed [VALUE_WIDTH-1:0] lv_q, lv_d;
  logic signed [VALUE_WIDTH-1:0] pv_q, pv_d;
  logic signed [VALUE_WIDTH-1:0] root_q;
  logic signed [VALUE_WIDTH-1:0] removed_q, removed_d;
  logic                          err_q, err_d;

  logic                          out_valid_q, out_valid_d;
  logic signed [VALUE_WIDTH-1:0] out_min_q;
  logic signed [VALUE_WIDTH-1:0] out_removed_q;
  logic        [CW-1:0]          out_cnt_q;
  logic                          out_empty_q;
  logic                          out_err_q;
  logic                          out_load;

  logic                          wr_en;
  logic        [AW-1:0]          wr_addr;
  logic signed [VALUE_WIDTH-1:0] wr_data;
  logic                          rd_en;
  logic        [AW-1:0]          rd_addr;
  logic signed [VALUE_WIDTH-1:0] rd_data;

  logic signed [VALUE_WIDTH-1:0] cmp_a, cmp_b;
  logic                          cmp_gt;

  logic [AW-1:0] parent;
  logic [LW-1:0] left, right, cnt_ext;

  assign parent  = AW'((pos_q - AW'(1)) >> 1);
  assign left    = {pos_q, 1'b1};
  assign right   = {pos_q, 1'b0} + LW'(2);
  assign cnt_ext = LW'(cnt_q);

  bmhq_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(CAPACITY)
  ) u_heap_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_comb begin
    unique case (state_q)
      ST_UP_CMP: begin
        cmp_a = rd_data;
        cmp_b = cur_q;
      end
      ST_DN_PICK: begin
        cmp_a = lv_q;
        cmp_b = rd_data;
      end
      default: begin
        cmp_a = cur_q;
        cmp_b = pv_q;
      end
    endcase
  end

  assign cmp_gt = cmp_a > cmp_b;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    pick_d      = pick_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    lv_d        = lv_q;
    pv_d        = pv_q;
    removed_d   = removed_q;
    err_d       = err_q;
    wr_en       = 1'b0;
    wr_addr     = pos_q;
    wr_data     = cur_q;
    rd_en       = 1'b0;
    rd_addr     = parent;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    in_i.ready  = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          removed_d = '0;
          err_d     = 1'b0;
          if (in_i.mode == MODE_INSERT) begin
            if (cnt_q == CW'(CAPACITY)) begin
              err_d   = 1'b1;
              state_d = ST_DONE;
            end else begin
              pos_d   = AW'(cnt_q);
              cur_d   = in_i.value;
              cnt_d   = cnt_q + CW'(1);
              state_d = ST_UP_RD;
            end
          end else begin
            if (cnt_q == '0) begin
              err_d   = 1'b1;
              state_d = ST_DONE;
            end else begin
              removed_d = root_q;
              cnt_d     = cnt_q - CW'(1);
              state_d   = (cnt_q == CW'(1)) ? ST_DONE : ST_DN_LAST_RD;
            end
          end
        end
      end
      ST_UP_RD: begin
        if (pos_q == '0) begin
          wr_en   = 1'b1;
          state_d = ST_DONE;
        end else begin
          rd_en   = 1'b1;
          state_d = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        wr_en = 1'b1;
        if (cmp_gt) begin
          wr_data = rd_data;
          pos_d   = parent;
          state_d = ST_UP_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DN_LAST_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(cnt_q);
        state_d = ST_DN_LAST;
      end
      ST_DN_LAST: begin
        cur_d   = rd_data;
        pos_d   = '0;
        state_d = ST_DN_RDL;
      end
      ST_DN_RDL: begin
        if (left >= cnt_ext) begin
          wr_en   = 1'b1;
          state_d = ST_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(left);
          state_d = ST_DN_RDR;
        end
      end
      ST_DN_RDR: begin
        lv_d = rd_data;
        if (right < cnt_ext) begin
          rd_en   = 1'b1;
          rd_addr = AW'(right);
          state_d = ST_DN_PICK;
        end else begin
          pv_d    = rd_data;
          pick_d  = AW'(left);
          state_d = ST_DN_SWP;
        end
      end
      ST_DN_PICK: begin
        if (cmp_gt) begin
          pv_d   = rd_data;
          pick_d = AW'(right);
        end else begin
          pv_d   = lv_q;
          pick_d = AW'(left);
        end
        state_d = ST_DN_SWP;
      end
      ST_DN_SWP: begin
        wr_en = 1'b1;
        if (cmp_gt) begin
          wr_data = pv_q;
          pos_d   = pick_q;
          state_d = ST_DN_RDL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    pick_q    <= pick_d;
    cur_q     <= cur_d;
    lv_q      <= lv_d;
    pv_q      <= pv_d;
    removed_q <= removed_d;
    err_q     <= err_d;
    if (wr_en && wr_addr == '0) begin
      root_q <= wr_data;
    end
    if (out_load) begin
      out_min_q     <= (cnt_q != '0) ? root_q : '0;
      out_removed_q <= removed_q;
      out_cnt_q     <= cnt_q;
      out_empty_q   <= (cnt_q == '0);
      out_err_q     <= err_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.min_value     = out_min_q;
  assign out_o.removed_value = out_removed_q;
  assign out_o.count         = out_cnt_q;
  assign out_o.empty_res     = out_empty_q;
  assign out_o.error         = out_err_q;

endmodule
